### hw/rtl/ctsp_pkg.sv
// ----------------------------------------------------------------------------
// ctsp_pkg
// Shared types, sizes and the Curl substitution table for the ternary sponge.
// ----------------------------------------------------------------------------
package ctsp_pkg;

  localparam int STATE_TRITS = 729;
  localparam int RATE_TRITS  = 243;

  localparam int ADDR_W  = $clog2(STATE_TRITS);
  localparam int POS_W   = $clog2(RATE_TRITS + 1);
  localparam int ROUND_W = 7;

  // Trit index walk: +364 below the fold, -365 above it.
  localparam logic [ADDR_W-1:0] J_FWD  = ADDR_W'(364);
  localparam logic [ADDR_W-1:0] J_BACK = ADDR_W'(365);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_TRITS - 1);
  localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(STATE_TRITS);

  // Balanced trit, two's complement: 01 = +1, 00 = 0, 11 = -1.
  typedef logic signed [1:0] trit_t;

  localparam trit_t TRIT_ZERO = 2'b00;
  localparam trit_t TRIT_POS  = 2'b01;
  localparam trit_t TRIT_NEG  = 2'b11;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ABSORB  = 2'd1,
    OP_SQUEEZE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  // Curl S-box: new trit from previous trit a and current trit b,
  // i.e. table {1,0,-1,2,1,-1,0,2,-1,1,0} at a + 4*b + 5.
  function automatic trit_t curl_lut(input trit_t a, input trit_t b);
    trit_t r;
    case ({a, b})
      {TRIT_NEG,  TRIT_NEG}:  r = TRIT_POS;
      {TRIT_ZERO, TRIT_NEG}:  r = TRIT_ZERO;
      {TRIT_POS,  TRIT_NEG}:  r = TRIT_NEG;
      {TRIT_NEG,  TRIT_ZERO}: r = TRIT_POS;
      {TRIT_ZERO, TRIT_ZERO}: r = TRIT_NEG;
      {TRIT_POS,  TRIT_ZERO}: r = TRIT_ZERO;
      {TRIT_NEG,  TRIT_POS}:  r = TRIT_NEG;
      {TRIT_ZERO, TRIT_POS}:  r = TRIT_POS;
      {TRIT_POS,  TRIT_POS}:  r = TRIT_ZERO;
      default:                r = TRIT_ZERO;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/ctsp_ram.sv
// ----------------------------------------------------------------------------
// ctsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctsp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 729
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/curl_ternary_sponge_core.sv
// ----------------------------------------------------------------------------
// curl_ternary_sponge_core
// Curl-P ternary sponge over a 729-trit state, one trit per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries opcode, trit and block end.
// Clear zeroes the state and returns nothing; absorb and squeeze each return
// one transaction on the output channel (out_valid_o/out_ready_i) with the
// squeezed trit (zero for absorb) and a flag telling whether a permutation
// ran. The block works on one transaction at a time; in_ready_o is low while
// it is busy.
// Absorb and squeeze run a permutation of round_count rounds when the
// position reaches the rate or block end is set, each round making one state
// RAM read per trit plus pipeline fill.
// The state lives in two 729 x 2-bit RAMs used ping-pong, one round reading
// one bank and writing the other. Clear runs a zeroing sweep over all 729 trits.
// After reset the same zeroing sweep runs before the first transaction is
// taken; APB writes are taken at any time. A stalled receiver holds the
// result in the output register; the next transaction is still accepted and
// its result waits until the register frees.
// round_count sits at APB byte address 0 (reset 81).
// ----------------------------------------------------------------------------
module curl_ternary_sponge_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  ctsp_pkg::trit_t       trit_in_i,
  input  logic                  block_end_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctsp_pkg::trit_t       trit_out_o,
  output logic                  transformed_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ctsp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ROUND,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [ROUND_W-1:0]  round_count_q, round_count_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                cur_q, cur_d;
  logic [ADDR_W-1:0]   clr_addr_q, clr_addr_d;
  logic [ROUND_W-1:0]  rounds_left_q, rounds_left_d;
  logic [ADDR_W-1:0]   k_q, k_d;
  logic [ADDR_W-1:0]   j_q, j_d;
  logic                iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]   rd_k_q, rd_k_d;
  trit_t               a_q, a_d;
  trit_t               res_trit_q, res_trit_d;
  logic                res_xf_q, res_xf_d;
  logic                out_valid_q, out_valid_d;
  trit_t               trit_out_q, trit_out_d;
  logic                transformed_q, transformed_d;

  logic                in_fire;
  logic                wr_en;
  logic                wr_bank;
  logic [ADDR_W-1:0]   wr_addr;
  trit_t               wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  trit_t               rdata0, rdata1, rdata;
  trit_t               absorb_trit;
  logic [POS_W-1:0]    pos_inc;
  logic                do_xf;
  logic                cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(round_count_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // saturate the unused pattern to -1
  assign absorb_trit = (trit_in_i == TRIT_ZERO) ? TRIT_ZERO :
                       (trit_in_i == TRIT_POS)  ? TRIT_POS : TRIT_NEG;
  assign pos_inc = pos_q + POS_W'(1);
  assign do_xf   = (pos_inc >= POS_W'(RATE_TRITS)) || block_end_i;

  assign rdata = cur_q ? rdata1 : rdata0;

  // --------------------------------------------------------------------------
  // RAM access steering
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = cur_q;
    wr_addr = clr_addr_q;
    wr_data = TRIT_ZERO;
    rd_addr = (state_q == ST_ROUND) ? j_q : ADDR_W'(pos_q);
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        if (in_fire && (opcode_i == OP_ABSORB)) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(pos_q);
          wr_data = absorb_trit;
        end
      end
      ST_ROUND: begin
        // first read of a round only seeds the carry trit
        if (rd_vld_q && (rd_k_q != '0)) begin
          wr_en   = 1'b1;
          wr_bank = !cur_q;
          wr_addr = rd_k_q - ADDR_W'(1);
          wr_data = curl_lut(a_q, rdata);
        end
      end
      default: ;
    endcase
  end

  ctsp_ram #(.WIDTH(2), .DEPTH(STATE_TRITS)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_bank),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  ctsp_ram #(.WIDTH(2), .DEPTH(STATE_TRITS)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_bank),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    round_count_d = cfg_wr ? pwdata[ROUND_W-1:0] : round_count_q;
    pos_d         = pos_q;
    cur_d         = cur_q;
    clr_addr_d    = clr_addr_q;
    rounds_left_d = rounds_left_q;
    k_d           = k_q;
    j_d           = j_q;
    iss_d         = iss_q;
    rd_vld_d      = 1'b0;
    rd_k_d        = rd_k_q;
    a_d           = a_q;
    res_trit_d    = res_trit_q;
    res_xf_d      = res_xf_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    trit_out_d    = trit_out_q;
    transformed_d = transformed_q;

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // prime the round counters; used only if a permutation follows
        rounds_left_d = round_count_q;
        k_d           = '0;
        j_d           = '0;
        iss_d         = 1'b1;
        if (in_fire) begin
          case (opcode_i)
            OP_CLEAR: begin
              pos_d      = '0;
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            OP_ABSORB, OP_SQUEEZE: begin
              pos_d      = do_xf ? '0 : pos_inc;
              res_xf_d   = do_xf;
              res_trit_d = TRIT_ZERO;
              if (opcode_i == OP_SQUEEZE) begin
                state_d = ST_READ;
              end else if (do_xf && (round_count_q != '0)) begin
                state_d = ST_ROUND;
              end else begin
                state_d = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        res_trit_d = rdata;
        if (res_xf_q && (rounds_left_q != '0)) begin
          state_d = ST_ROUND;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_ROUND: begin
        if (iss_q) begin
          rd_vld_d = 1'b1;
          rd_k_d   = k_q;
          if (k_q == LAST_STEP) begin
            iss_d = 1'b0;
          end else begin
            k_d = k_q + ADDR_W'(1);
            j_d = (j_q < J_BACK) ? (j_q + J_FWD) : (j_q - J_BACK);
          end
        end
        if (rd_vld_q) begin
          a_d = rdata;
          if (rd_k_q == LAST_STEP) begin
            // round done: the freshly written bank now holds the state
            cur_d         = !cur_q;
            rounds_left_d = rounds_left_q - ROUND_W'(1);
            k_d           = '0;
            j_d           = '0;
            iss_d         = 1'b1;
            if (rounds_left_q == ROUND_W'(1)) begin
              state_d = ST_EMIT;
            end
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          trit_out_d    = res_trit_q;
          transformed_d = res_xf_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      round_count_q <= ROUND_W'(81);
      pos_q         <= '0;
      cur_q         <= 1'b0;
      clr_addr_q    <= '0;
      rounds_left_q <= '0;
      k_q           <= '0;
      j_q           <= '0;
      iss_q         <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_k_q        <= '0;
      a_q           <= TRIT_ZERO;
      res_trit_q    <= TRIT_ZERO;
      res_xf_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      trit_out_q    <= TRIT_ZERO;
      transformed_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      round_count_q <= round_count_d;
      pos_q         <= pos_d;
      cur_q         <= cur_d;
      clr_addr_q    <= clr_addr_d;
      rounds_left_q <= rounds_left_d;
      k_q           <= k_d;
      j_q           <= j_d;
      iss_q         <= iss_d;
      rd_vld_q      <= rd_vld_d;
      rd_k_q        <= rd_k_d;
      a_q           <= a_d;
      res_trit_q    <= res_trit_d;
      res_xf_q      <= res_xf_d;
      out_valid_q   <= out_valid_d;
      trit_out_q    <= trit_out_d;
      transformed_q <= transformed_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trit_out_o    = trit_out_q;
  assign transformed_o = transformed_q;

`ifndef SYNTHESIS
  // the bank holding the state swaps only at the end of a round
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(state_q) == ST_ROUND))
    else $error("state bank swapped outside a round");

  // trit walk stays inside the state
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (j_q < ADDR_W'(STATE_TRITS)))
    else $error("trit index out of range");

  // position never rests at or beyond the rate
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(RATE_TRITS))
    else $error("block position out of range");

  // a new result only comes from the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_EMIT))
    else $error("result loaded outside emit");
`endif

endmodule

### tb/sponge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sponge_checker
// Watches the trit and result channels and the APB port of the Curl sponge.
// Keeps its own copy of the 729-trit state, the rate position and the round
// count, predicts each absorb/squeeze result and compares it field by field
// with what the block returns, in order.
// ----------------------------------------------------------------------------
module sponge_checker
  import ctsp_pkg::*;
#(
  parameter logic [2:0] ROUND_COUNT_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  trit_t       trit_in_i,
  input  logic        block_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  trit_t       trit_out_i,
  input  logic        transformed_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          perm_count_o
);

  localparam int MAX_REPORTS = 100;

  // Curl substitution, indexed by prev + 4 * cur + 5
  localparam int CURL_SBOX [11] = '{1, 0, -1, 2, 1, -1, 0, 2, -1, 1, 0};

  typedef struct packed {
    trit_t trit;
    logic  transformed;
  } sponge_result_t;

  trit_t               sponge [STATE_TRITS];
  trit_t               scratch [STATE_TRITS];
  int unsigned         rate_pos;
  logic [ROUND_W-1:0]  round_cfg;
  sponge_result_t      due_results_q [$];

  initial begin
    foreach (sponge[k]) sponge[k] = TRIT_ZERO;
    foreach (scratch[k]) scratch[k] = TRIT_ZERO;
    rate_pos     = 0;
    round_cfg    = ROUND_W'(81);
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    perm_count_o = 0;
  end

  function automatic void note_fail(string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) $error("%s", msg);
    if (fail_count_o == MAX_REPORTS) $display("further mismatches counted, not printed");
  endfunction

  function automatic trit_t sbox(trit_t a, trit_t b);
    return trit_t'(CURL_SBOX[int'(a) + 4 * int'(b) + 5]);
  endfunction

  // The index walk carries across rounds; the previous trit restarts per round.
  function automatic void curl_rounds();
    int unsigned j;
    trit_t       a;
    trit_t       b;
    j = 0;
    for (int r = 0; r < int'(round_cfg); r++) begin
      scratch = sponge;
      a = scratch[j];
      for (int i = 0; i < STATE_TRITS; i++) begin
        j = (j < J_BACK) ? j + J_FWD : j - J_BACK;
        b = scratch[j % STATE_TRITS];
        sponge[i] = sbox(a, b);
        a = b;
      end
    end
  endfunction

  function automatic void step_sponge(opcode_e op, trit_t t, logic last);
    sponge_result_t res;
    res.trit        = TRIT_ZERO;
    res.transformed = 1'b0;
    case (op)
      OP_CLEAR: begin
        foreach (sponge[k]) sponge[k] = TRIT_ZERO;
        rate_pos = 0;
      end
      OP_ABSORB, OP_SQUEEZE: begin
        rate_pos = rate_pos % RATE_TRITS;
        if (op == OP_ABSORB) begin
          // saturate the unused pattern to -1
          sponge[rate_pos] = (t == TRIT_ZERO) ? TRIT_ZERO :
                             (t == TRIT_POS)  ? TRIT_POS  : TRIT_NEG;
        end else begin
          res.trit = sponge[rate_pos];
        end
        rate_pos++;
        if (rate_pos >= RATE_TRITS || last) begin
          curl_rounds();
          rate_pos = 0;
          res.transformed = 1'b1;
          perm_count_o++;
        end
        due_results_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    sponge_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        step_sponge(opcode_e'(opcode_i), trit_in_i, block_end_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results_q.size() == 0) begin
          note_fail($sformatf("unexpected transaction: trit_out %0d, transformed %0b",
                              trit_out_i, transformed_i));
        end else begin
          want = due_results_q.pop_front();
          checked_o++;
          if (trit_out_i !== want.trit) begin
            note_fail($sformatf("trit_out: expected %0d, actual %0d", want.trit, trit_out_i));
          end
          if (transformed_i !== want.transformed) begin
            note_fail($sformatf("transformed: expected %0b, actual %0b",
                                want.transformed, transformed_i));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ROUND_COUNT_ADDR) begin
        round_cfg = pwdata_i[ROUND_W-1:0];
      end
      pending_o = due_results_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Curl ternary sponge core. Drives directed
// trits, then random absorb/squeeze messages under several round counts,
// with bursty input traffic and a stalling receiver; sponge_checker predicts
// and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ctsp_pkg::*;

  localparam logic [2:0] ROUND_COUNT_ADDR = 3'd0;
  localparam int         SETTLE_CYCLES    = 800;
  localparam trit_t      TRIT_OVER        = 2'b10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i    = OP_NONE;
  trit_t       trit_in_i   = TRIT_ZERO;
  logic        block_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  trit_t       trit_out_o;
  logic        transformed_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          perms;
  int          burst_left  = 0;
  int unsigned rx_tick     = 0;

  always #10 clk_i = ~clk_i;

  curl_ternary_sponge_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .trit_in_i     (trit_in_i),
    .block_end_i   (block_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trit_out_o    (trit_out_o),
    .transformed_o (transformed_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sponge_checker #(
    .ROUND_COUNT_ADDR (ROUND_COUNT_ADDR)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .trit_in_i     (trit_in_i),
    .block_end_i   (block_end_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trit_out_i    (trit_out_o),
    .transformed_i (transformed_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .perm_count_o  (perms)
  );

  // Receiver: free-running, then coin-flip, then sparse, then long stalls.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[10:9])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 1) == 0);
      2'd2:    out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (rx_tick[5:0] == 6'd0);
    endcase
  end

  function automatic trit_t rand_trit();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return TRIT_OVER;
    case (r % 3)
      0:       return TRIT_ZERO;
      1:       return TRIT_POS;
      default: return TRIT_NEG;
    endcase
  endfunction

  // Present one transaction and hold it until accepted. Called at a clock edge.
  task automatic drive_item(input opcode_e op, input trit_t t, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    trit_in_i   <= t;
    block_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, drain all results, then let any clear sweep finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rounds(input logic [ROUND_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROUND_COUNT_ADDR;
    pwdata  <= {(32 - ROUND_W)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Messages: optional clear, an absorb run, a squeeze run; noise mixed in.
  task automatic send_messages(input int items, input int end_pct, input bit stray_ends);
    int      sent;
    int      n_abs;
    int      n_sqz;
    opcode_e op;
    logic    last;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) drive_item(OP_CLEAR, rand_trit(), 1'($urandom));
      n_abs = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 260) : $urandom_range(1, 60);
      n_sqz = $urandom_range(1, 60);
      for (int k = 0; k < n_abs + n_sqz; k++) begin
        if (sent >= items) break;
        op   = (k < n_abs) ? OP_ABSORB : OP_SQUEEZE;
        last = (k == n_abs - 1 || k == n_abs + n_sqz - 1) &&
               ($urandom_range(0, 99) < end_pct);
        if (stray_ends && $urandom_range(0, 49) == 0) last = 1'b1;
        if ($urandom_range(0, 24) == 0) begin
          drive_item(OP_NONE, trit_t'($urandom_range(0, 3)), 1'($urandom));
        end
        drive_item(op, (op == OP_ABSORB) ? rand_trit() : trit_t'($urandom_range(0, 3)), last);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed trits at the reset round count
    drive_item(OP_SQUEEZE, TRIT_POS,  1'b0);
    drive_item(OP_ABSORB,  TRIT_POS,  1'b0);
    drive_item(OP_ABSORB,  TRIT_NEG,  1'b0);
    drive_item(OP_ABSORB,  TRIT_ZERO, 1'b0);
    drive_item(OP_ABSORB,  TRIT_OVER, 1'b0);
    drive_item(OP_NONE,    TRIT_POS,  1'b1);
    drive_item(OP_SQUEEZE, TRIT_OVER, 1'b0);
    drive_item(OP_CLEAR,   TRIT_NEG,  1'b1);
    drive_item(OP_SQUEEZE, TRIT_ZERO, 1'b0);
    drive_item(OP_ABSORB,  TRIT_POS,  1'b0);
    drive_item(OP_ABSORB,  TRIT_NEG,  1'b0);
    drive_item(OP_ABSORB,  TRIT_OVER, 1'b1);
    repeat (4) drive_item(OP_SQUEEZE, trit_t'($urandom_range(0, 3)), 1'b0);
    drive_item(OP_SQUEEZE, TRIT_NEG,  1'b1);
    drive_item(OP_ABSORB,  TRIT_NEG,  1'b0);
    drive_item(OP_SQUEEZE, TRIT_POS,  1'b0);
    drive_item(OP_CLEAR,   TRIT_ZERO, 1'b0);
    drive_item(OP_SQUEEZE, TRIT_ZERO, 1'b0);
    settle();

    write_rounds(ROUND_W'(1));
    send_messages(500, 60, 1'b1);
    settle();

    // zero rounds: state holds, position still wraps
    write_rounds(ROUND_W'(0));
    send_messages(150, 60, 1'b1);
    settle();

    // longest transform: one short block only
    write_rounds(ROUND_W'(127));
    drive_item(OP_CLEAR, rand_trit(), 1'b0);
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) drive_item(OP_ABSORB, rand_trit(), 1'b0);
      else drive_item(OP_SQUEEZE, rand_trit(), 1'b0);
    end
    drive_item(OP_SQUEEZE, rand_trit(), 1'b1);
    repeat (8) drive_item(OP_SQUEEZE, rand_trit(), 1'b0);
    settle();

    write_rounds(ROUND_W'(27));
    send_messages(200, 10, 1'b0);
    settle();

    write_rounds(ROUND_W'(3));
    send_messages(450, 40, 1'b1);
    settle();

    $display("Checked %0d result transactions across %0d permutations", checked, perms);
    $display("Round counts exercised: 81 (reset), 1, 0, 127, 27, 3");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/ctsp_pkg.sv
hw/rtl/ctsp_ram.sv
hw/rtl/curl_ternary_sponge_core.sv
tb/sponge_checker.sv
tb/testbench.sv
